// ----- rtl/core/oriented_box_overlap_test_unit_macros.svh -----
// Assertion macros shared by the checker of the oriented box overlap test unit.
// Depends on nothing; included by the files that hold concurrent assertions.
`ifndef ORIENTED_BOX_OVERLAP_TEST_UNIT_MACROS_SVH
`define ORIENTED_BOX_OVERLAP_TEST_UNIT_MACROS_SVH

// Checked at every rising clock edge outside reset.
`define OBOX_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define OBOX_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/obox_pkg.sv -----
// Package of the oriented box overlap test unit: widths, types, the quarter-wave
// sine table builder and the angle reduction function. Depends on nothing.
package obox_pkg;

   localparam int COORD_FRAC_BITS        = 8;
   localparam int TRIG_FRAC_BITS         = 15;
   localparam int ANGLE_STEPS_PER_DEGREE = 16;

   localparam int QUARTER_STEPS = 90 * ANGLE_STEPS_PER_DEGREE;
   localparam int HALF_STEPS    = 180 * ANGLE_STEPS_PER_DEGREE;
   localparam int FULL_STEPS    = 360 * ANGLE_STEPS_PER_DEGREE;

   localparam int POS_W   = 24;
   localparam int SIZE_W  = 22;
   localparam int ANGLE_W = 13;
   localparam int AIDX_W  = $clog2(QUARTER_STEPS + 1);
   localparam int MAG_W   = TRIG_FRAC_BITS + 1;
   localparam int TRIG_W  = TRIG_FRAC_BITS + 2;
   localparam int CTR_W   = POS_W + 2;
   localparam int MUL_W   = SIZE_W + 1 + TRIG_W;
   localparam int OFS_W   = MUL_W + 1;
   localparam int RND_W   = OFS_W - TRIG_FRAC_BITS;
   localparam int PT_W    = CTR_W + 1;
   localparam int PROD_W  = PT_W + TRIG_W;
   localparam int PROJ_W  = PROD_W + 1;

   localparam longint unsigned PI_Q30 = 64'd3373259426;

   typedef logic [MAG_W-1:0] sin_table_type [0:QUARTER_STEPS];

   typedef struct packed {
      logic [AIDX_W-1:0] idx;
      logic              neg;
   } trig_addr_type;

   typedef struct packed {
      logic [3:0][PT_W-1:0] px;
      logic [3:0][PT_W-1:0] py;
      logic [TRIG_W-1:0]    s;
      logic [TRIG_W-1:0]    c;
   } box_geom_type;

   function automatic longint unsigned taylor_term(input longint unsigned term,
                                                   input longint unsigned x2);
      taylor_term = (term * x2 + (64'd1 << 29)) >> 30;
   endfunction

   function automatic logic [MAG_W-1:0] quarter_sin(input int k);
      longint unsigned x, x2, term, sum, r;
      x    = (longint'(k) * PI_Q30 + HALF_STEPS / 2) / HALF_STEPS;
      x2   = (x * x + (64'd1 << 29)) >> 30;
      sum  = x;
      term = taylor_term(x, x2) / 6;
      sum  = (sum >= term) ? sum - term : 64'd0;
      term = taylor_term(term, x2) / 20;
      sum  = sum + term;
      term = taylor_term(term, x2) / 42;
      sum  = (sum >= term) ? sum - term : 64'd0;
      term = taylor_term(term, x2) / 72;
      sum  = sum + term;
      term = taylor_term(term, x2) / 110;
      sum  = (sum >= term) ? sum - term : 64'd0;
      term = taylor_term(term, x2) / 156;
      sum  = sum + term;
      term = taylor_term(term, x2) / 210;
      sum  = (sum >= term) ? sum - term : 64'd0;
      term = taylor_term(term, x2) / 272;
      sum  = sum + term;
      term = taylor_term(term, x2) / 342;
      sum  = (sum >= term) ? sum - term : 64'd0;
      term = taylor_term(term, x2) / 420;
      sum  = sum + term;
      term = taylor_term(term, x2) / 506;
      sum  = (sum >= term) ? sum - term : 64'd0;
      term = taylor_term(term, x2) / 600;
      sum  = sum + term;
      r = (sum + (64'd1 << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS);
      if (r > (64'd1 << TRIG_FRAC_BITS)) begin
         r = 64'd1 << TRIG_FRAC_BITS;
      end
      quarter_sin = r[MAG_W-1:0];
   endfunction

   function automatic sin_table_type build_sin_table();
      sin_table_type t;
      for (int k = 0; k <= QUARTER_STEPS; k++) begin
         t[k] = quarter_sin(k);
      end
      build_sin_table = t;
   endfunction

   // Folds an angle below twice a full turn into a table index and a sign.
   function automatic trig_addr_type reduce_angle(input logic [ANGLE_W:0] a);
      trig_addr_type    res;
      logic [ANGLE_W:0] a1;
      logic [ANGLE_W:0] r;
      logic [1:0]       q;
      a1 = (a >= (ANGLE_W+1)'(FULL_STEPS)) ? a - (ANGLE_W+1)'(FULL_STEPS) : a;
      if (a1 < (ANGLE_W+1)'(QUARTER_STEPS)) begin
         q = 2'd0;
         r = a1;
      end else if (a1 < (ANGLE_W+1)'(2 * QUARTER_STEPS)) begin
         q = 2'd1;
         r = a1 - (ANGLE_W+1)'(QUARTER_STEPS);
      end else if (a1 < (ANGLE_W+1)'(3 * QUARTER_STEPS)) begin
         q = 2'd2;
         r = a1 - (ANGLE_W+1)'(2 * QUARTER_STEPS);
      end else begin
         q = 2'd3;
         r = a1 - (ANGLE_W+1)'(3 * QUARTER_STEPS);
      end
      if (q[0]) begin
         r = (ANGLE_W+1)'(QUARTER_STEPS) - r;
      end
      res.idx = r[AIDX_W-1:0];
      res.neg = q[1];
      reduce_angle = res;
   endfunction

endpackage

// ----- rtl/core/obox_sin_rom.sv -----
// Quarter-wave sine ROM with two registered read ports.
// Depends on obox_pkg for the table contents and widths.
module obox_sin_rom (
   input  logic                           clock,
   input  logic                           enable,
   input  logic [obox_pkg::AIDX_W-1:0]    addr_a,
   input  logic [obox_pkg::AIDX_W-1:0]    addr_b,
   output logic [obox_pkg::MAG_W-1:0]     data_a,
   output logic [obox_pkg::MAG_W-1:0]     data_b
);
   import obox_pkg::*;

   localparam sin_table_type ROM = build_sin_table();

   logic [MAG_W-1:0] data_a_ff;
   logic [MAG_W-1:0] data_b_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         data_a_ff <= ROM[addr_a];
         data_b_ff <= ROM[addr_b];
      end
   end

   assign data_a = data_a_ff;
   assign data_b = data_b_ff;
endmodule

// ----- rtl/core/obox_box_geom.sv -----
// Four-stage pipeline that turns one box into its sine, cosine and rotated corners.
// Depends on obox_pkg and obox_sin_rom.
module obox_box_geom (
   input  logic                               clock,
   input  logic                               enable,
   input  logic signed [obox_pkg::POS_W-1:0]  left,
   input  logic signed [obox_pkg::POS_W-1:0]  top,
   input  logic [obox_pkg::SIZE_W-1:0]        width,
   input  logic [obox_pkg::SIZE_W-1:0]        height,
   input  logic [obox_pkg::ANGLE_W-1:0]       angle,
   output obox_pkg::box_geom_type             geom
);
   import obox_pkg::*;

   trig_addr_type            sin_addr_in, cos_addr_in;
   logic signed [CTR_W-1:0]  cx_in, cy_in;

   logic                     sin_neg1_ff, cos_neg1_ff;
   logic signed [CTR_W-1:0]  cx1_ff, cy1_ff;
   logic [SIZE_W-1:0]        w1_ff, h1_ff;

   logic [MAG_W-1:0]         sin_mag, cos_mag;
   logic [MAG_W-1:0]         sin_mag2_ff, cos_mag2_ff;
   logic                     sin_neg2_ff, cos_neg2_ff;
   logic signed [CTR_W-1:0]  cx2_ff, cy2_ff;
   logic [SIZE_W-1:0]        w2_ff, h2_ff;

   logic signed [TRIG_W-1:0] s_in, c_in;
   logic signed [MUL_W-1:0]  wc_in, hs_in, ws_in, hc_in;
   logic signed [MUL_W-1:0]  wc3_ff, hs3_ff, ws3_ff, hc3_ff;
   logic signed [TRIG_W-1:0] s3_ff, c3_ff;
   logic signed [CTR_W-1:0]  cx3_ff, cy3_ff;

   box_geom_type             geom_in, geom_ff;

   always_comb begin
      sin_addr_in = reduce_angle({1'b0, angle});
      cos_addr_in = reduce_angle({1'b0, angle} + (ANGLE_W+1)'(QUARTER_STEPS));
      cx_in = {left[POS_W-1], left, 1'b0} + $signed({2'b00, width});
      cy_in = {top[POS_W-1], top, 1'b0} + $signed({2'b00, height});
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sin_neg1_ff <= sin_addr_in.neg;
         cos_neg1_ff <= cos_addr_in.neg;
         cx1_ff      <= cx_in;
         cy1_ff      <= cy_in;
         w1_ff       <= width;
         h1_ff       <= height;
      end
   end

   obox_sin_rom u_rom (
      .clock  (clock),
      .enable (enable),
      .addr_a (sin_addr_in.idx),
      .addr_b (cos_addr_in.idx),
      .data_a (sin_mag),
      .data_b (cos_mag)
   );

   always_ff @(posedge clock) begin
      if (enable) begin
         sin_mag2_ff <= sin_mag;
         cos_mag2_ff <= cos_mag;
         sin_neg2_ff <= sin_neg1_ff;
         cos_neg2_ff <= cos_neg1_ff;
         cx2_ff      <= cx1_ff;
         cy2_ff      <= cy1_ff;
         w2_ff       <= w1_ff;
         h2_ff       <= h1_ff;
      end
   end

   always_comb begin
      s_in  = sin_neg2_ff ? -$signed({1'b0, sin_mag2_ff}) : $signed({1'b0, sin_mag2_ff});
      c_in  = cos_neg2_ff ? -$signed({1'b0, cos_mag2_ff}) : $signed({1'b0, cos_mag2_ff});
      wc_in = $signed({1'b0, w2_ff}) * c_in;
      hs_in = $signed({1'b0, h2_ff}) * s_in;
      ws_in = $signed({1'b0, w2_ff}) * s_in;
      hc_in = $signed({1'b0, h2_ff}) * c_in;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         wc3_ff <= wc_in;
         hs3_ff <= hs_in;
         ws3_ff <= ws_in;
         hc3_ff <= hc_in;
         s3_ff  <= s_in;
         c3_ff  <= c_in;
         cx3_ff <= cx2_ff;
         cy3_ff <= cy2_ff;
      end
   end

   // Corner offsets are rounded half up, which is an arithmetic shift of the
   // offset plus one half.
   always_comb begin
      logic signed [OFS_W-1:0] vx, vy, lwc, lws, lhs, lhc;
      logic signed [OFS_W-1:0] half;
      logic signed [RND_W-1:0] rx, ry;
      half = OFS_W'(1) <<< (TRIG_FRAC_BITS - 1);
      geom_in.s = s3_ff;
      geom_in.c = c3_ff;
      for (int i = 0; i < 4; i++) begin
         lwc = ((i & 1) != 0) ? OFS_W'(wc3_ff) : -OFS_W'(wc3_ff);
         lws = ((i & 1) != 0) ? OFS_W'(ws3_ff) : -OFS_W'(ws3_ff);
         lhs = ((i & 2) != 0) ? OFS_W'(hs3_ff) : -OFS_W'(hs3_ff);
         lhc = ((i & 2) != 0) ? OFS_W'(hc3_ff) : -OFS_W'(hc3_ff);
         vx = lwc - lhs + half;
         vy = lws + lhc + half;
         rx = vx[OFS_W-1:TRIG_FRAC_BITS];
         ry = vy[OFS_W-1:TRIG_FRAC_BITS];
         geom_in.px[i] = PT_W'(cx3_ff) + PT_W'(rx);
         geom_in.py[i] = PT_W'(cy3_ff) + PT_W'(ry);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         geom_ff <= geom_in;
      end
   end

   assign geom = geom_ff;
endmodule

// ----- rtl/core/obox_sat.sv -----
// Four-stage separating axis test: projections, sums, interval ends and the verdict.
// Depends on obox_pkg.
module obox_sat (
   input  logic                   clock,
   input  logic                   enable,
   input  obox_pkg::box_geom_type geom_a,
   input  obox_pkg::box_geom_type geom_b,
   output logic                   overlap
);
   import obox_pkg::*;

   logic signed [TRIG_W-1:0] nx [4];
   logic signed [TRIG_W-1:0] ny [4];

   logic signed [PROD_W-1:0] pax_ff [4][4];
   logic signed [PROD_W-1:0] pay_ff [4][4];
   logic signed [PROD_W-1:0] pbx_ff [4][4];
   logic signed [PROD_W-1:0] pby_ff [4][4];

   logic signed [PROJ_W-1:0] proj_a_ff [4][4];
   logic signed [PROJ_W-1:0] proj_b_ff [4][4];

   logic signed [PROJ_W-1:0] lo_a_ff [4];
   logic signed [PROJ_W-1:0] hi_a_ff [4];
   logic signed [PROJ_W-1:0] lo_b_ff [4];
   logic signed [PROJ_W-1:0] hi_b_ff [4];

   logic overlap_in, overlap_ff;

   always_comb begin
      nx[0] = $signed(geom_a.c);
      ny[0] = $signed(geom_a.s);
      nx[1] = -$signed(geom_a.s);
      ny[1] = $signed(geom_a.c);
      nx[2] = $signed(geom_b.c);
      ny[2] = $signed(geom_b.s);
      nx[3] = -$signed(geom_b.s);
      ny[3] = $signed(geom_b.c);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
               pax_ff[i][j] <= $signed(geom_a.px[j]) * nx[i];
               pay_ff[i][j] <= $signed(geom_a.py[j]) * ny[i];
               pbx_ff[i][j] <= $signed(geom_b.px[j]) * nx[i];
               pby_ff[i][j] <= $signed(geom_b.py[j]) * ny[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
               proj_a_ff[i][j] <= PROJ_W'(pax_ff[i][j]) + PROJ_W'(pay_ff[i][j]);
               proj_b_ff[i][j] <= PROJ_W'(pbx_ff[i][j]) + PROJ_W'(pby_ff[i][j]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i < 4; i++) begin
            lo_a_ff[i] <= min4(proj_a_ff[i][0], proj_a_ff[i][1],
                               proj_a_ff[i][2], proj_a_ff[i][3]);
            hi_a_ff[i] <= max4(proj_a_ff[i][0], proj_a_ff[i][1],
                               proj_a_ff[i][2], proj_a_ff[i][3]);
            lo_b_ff[i] <= min4(proj_b_ff[i][0], proj_b_ff[i][1],
                               proj_b_ff[i][2], proj_b_ff[i][3]);
            hi_b_ff[i] <= max4(proj_b_ff[i][0], proj_b_ff[i][1],
                               proj_b_ff[i][2], proj_b_ff[i][3]);
         end
      end
   end

   // Touching intervals are not a gap.
   always_comb begin
      overlap_in = 1'b1;
      for (int i = 0; i < 4; i++) begin
         if ((hi_a_ff[i] < lo_b_ff[i]) || (hi_b_ff[i] < lo_a_ff[i])) begin
            overlap_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         overlap_ff <= overlap_in;
      end
   end

   assign overlap = overlap_ff;

   function automatic logic signed [PROJ_W-1:0] min4(
      input logic signed [PROJ_W-1:0] a, input logic signed [PROJ_W-1:0] b,
      input logic signed [PROJ_W-1:0] c, input logic signed [PROJ_W-1:0] d);
      logic signed [PROJ_W-1:0] m0, m1;
      m0 = (b < a) ? b : a;
      m1 = (d < c) ? d : c;
      min4 = (m1 < m0) ? m1 : m0;
   endfunction

   function automatic logic signed [PROJ_W-1:0] max4(
      input logic signed [PROJ_W-1:0] a, input logic signed [PROJ_W-1:0] b,
      input logic signed [PROJ_W-1:0] c, input logic signed [PROJ_W-1:0] d);
      logic signed [PROJ_W-1:0] m0, m1;
      m0 = (b > a) ? b : a;
      m1 = (d > c) ? d : c;
      max4 = (m1 > m0) ? m1 : m0;
   endfunction
endmodule

// ----- rtl/core/oriented_box_overlap_test_unit.sv -----
// Top level of the oriented box overlap test unit (2D separating axis test).
// Depends on obox_pkg, obox_box_geom and obox_sat.
//
//   Channel  Direction  Content
//   req      in         one pair of boxes per item
//   rsp      out        one overlap flag per item
//
// Eight register stages; one item is taken in every cycle in which the pipe does not hold.
// The two sine ROM reads and the sixty-four projection multiplies set the stage split.
// All stages advance together; when a result waits untaken, the whole pipe holds.
// Reset clears the stage valid bits only.
module oriented_box_overlap_test_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // a_left[23:0], a_top[47:24], a_width[69:48], a_height[91:70], a_angle[104:92],
   // b_left[128:105], b_top[152:129], b_width[174:153], b_height[196:175],
   // b_angle[209:197], zero fill[215:210]
   input  logic [215:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // overlap[0], zero fill[7:1]
   output logic [7:0]   rsp_tdata
);
   import obox_pkg::*;

   localparam int DEPTH = 8;

   logic [DEPTH-1:0] vld_ff, vld_in;
   logic             enable;
   logic             overlap;
   box_geom_type     geom_a, geom_b;

   assign enable     = !vld_ff[DEPTH-1] || rsp_tready;
   assign req_tready = enable;
   assign vld_in     = {vld_ff[DEPTH-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (enable) begin
         vld_ff <= vld_in;
      end
   end

   obox_box_geom u_box_a (
      .clock  (clock),
      .enable (enable),
      .left   ($signed(req_tdata[23:0])),
      .top    ($signed(req_tdata[47:24])),
      .width  (req_tdata[69:48]),
      .height (req_tdata[91:70]),
      .angle  (req_tdata[104:92]),
      .geom   (geom_a)
   );

   obox_box_geom u_box_b (
      .clock  (clock),
      .enable (enable),
      .left   ($signed(req_tdata[128:105])),
      .top    ($signed(req_tdata[152:129])),
      .width  (req_tdata[174:153]),
      .height (req_tdata[196:175]),
      .angle  (req_tdata[209:197]),
      .geom   (geom_b)
   );

   obox_sat u_sat (
      .clock   (clock),
      .enable  (enable),
      .geom_a  (geom_a),
      .geom_b  (geom_b),
      .overlap (overlap)
   );

   assign rsp_tvalid = vld_ff[DEPTH-1];
   assign rsp_tdata  = {7'b0000000, overlap};
endmodule

// ----- rtl/core/obox_checker.sv -----
// Port-level checker for the oriented box overlap test unit, bound to the top level.
// Depends on oriented_box_overlap_test_unit_macros.svh.
`include "oriented_box_overlap_test_unit_macros.svh"

module obox_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);
   `OBOX_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "stalled item dropped")
   `OBOX_ASSERT(a_full_stall, clock, reset, rsp_tvalid && !rsp_tready |-> !req_tready, "item taken while pipe is held")
   `OBOX_ASSERT(a_fill_zero, clock, reset, rsp_tvalid |-> rsp_tdata[7:1] == 7'b0000000, "fill bits not zero")
   `OBOX_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> !rsp_tvalid, "item shown after reset")
endmodule

bind oriented_box_overlap_test_unit obox_checker u_checker (.*);

// ----- sim/oriented_box_overlap_test_checker.sv -----
// Checker of the oriented box overlap test unit: it watches both channels, predicts
// the overlap flag of every accepted box pair and compares it with each result.
// Depends on nothing but its ports.
`timescale 1ns / 100ps

module oriented_box_overlap_test_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   // a_left, a_top, a_width, a_height, a_angle, b_left, b_top, b_width, b_height,
   // b_angle, zero fill
   input  logic [215:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   // overlap, zero fill
   input  logic [7:0]   rsp_tdata,
   output int           mismatches,
   output int           flags_pending
);

   localparam int ANGLE_SPD   = 16;
   localparam int QUARTER     = 90 * ANGLE_SPD;
   localparam int FULL_TURN   = 360 * ANGLE_SPD;
   localparam int FRAC        = 15;
   localparam longint unsigned PI_Q30_VAL = 64'd3373259426;

   longint sine_rom [0:QUARTER];
   bit     overlap_q [$];

   function automatic longint quarter_wave(input int k);
      longint unsigned x, x2, term, sum, r;
      x = (longint'(k) * PI_Q30_VAL + 64'(2 * QUARTER / 2)) / 64'(2 * QUARTER);
      x2 = (x * x + (64'd1 << 29)) >> 30;
      term = x;
      sum = x;
      for (int n = 1; n <= 12; n++) begin
         term = (term * x2 + (64'd1 << 29)) >> 30;
         term = term / (64'(2 * n) * 64'(2 * n + 1));
         if (n % 2 == 1) begin
            sum = (sum >= term) ? sum - term : 64'd0;
         end else begin
            sum = sum + term;
         end
      end
      r = (sum + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
      if (r > (64'd1 << FRAC)) begin
         r = 64'd1 << FRAC;
      end
      return longint'(r);
   endfunction

   function automatic longint sine_steps(input int a);
      int q, r;
      a = a % FULL_TURN;
      q = a / QUARTER;
      r = a % QUARTER;
      case (q)
         0: return sine_rom[r];
         1: return sine_rom[QUARTER - r];
         2: return -sine_rom[r];
         default: return -sine_rom[QUARTER - r];
      endcase
   endfunction

   function automatic void box_corners(input logic [104:0] box, input longint c,
                                       input longint s, output longint px[4],
                                       output longint py[4]);
      longint w, h, cx, cy, lx, ly;
      w = longint'(box[69:48]);
      h = longint'(box[91:70]);
      cx = 2 * longint'($signed(box[23:0])) + w;
      cy = 2 * longint'($signed(box[47:24])) + h;
      for (int i = 0; i < 4; i++) begin
         lx = (i % 2 == 1) ? w : -w;
         ly = (i >= 2) ? h : -h;
         px[i] = cx + ((lx * c - ly * s + 16384) >>> FRAC);
         py[i] = cy + ((lx * s + ly * c + 16384) >>> FRAC);
      end
   endfunction

   function automatic bit boxes_overlap(input logic [215:0] pair);
      longint ax[4], ay[4], bx[4], by[4], nx[4], ny[4];
      longint sa, ca, sb, cb, p, q, lo1, hi1, lo2, hi2;
      int ang_a, ang_b;
      ang_a = int'(pair[104:92]);
      ang_b = int'(pair[209:197]);
      sa = sine_steps(ang_a);
      ca = sine_steps(ang_a + QUARTER);
      sb = sine_steps(ang_b);
      cb = sine_steps(ang_b + QUARTER);
      box_corners(pair[104:0], ca, sa, ax, ay);
      box_corners(pair[209:105], cb, sb, bx, by);
      nx[0] = ca;  ny[0] = sa;
      nx[1] = -sa; ny[1] = ca;
      nx[2] = cb;  ny[2] = sb;
      nx[3] = -sb; ny[3] = cb;
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            p = ax[j] * nx[i] + ay[j] * ny[i];
            q = bx[j] * nx[i] + by[j] * ny[i];
            if (j == 0 || p < lo1) lo1 = p;
            if (j == 0 || p > hi1) hi1 = p;
            if (j == 0 || q < lo2) lo2 = q;
            if (j == 0 || q > hi2) hi2 = q;
         end
         if (hi1 < lo2 || hi2 < lo1) begin
            return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   initial begin
      mismatches = 0;
      flags_pending = 0;
      for (int k = 0; k <= QUARTER; k++) begin
         sine_rom[k] = quarter_wave(k);
      end
   end

   always @(posedge clock) begin
      bit want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (overlap_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("unexpected result item: overlap %0d", rsp_tdata[0]);
               end
            end else begin
               want = overlap_q.pop_front();
               if (rsp_tdata !== {7'd0, want}) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("overlap mismatch: expected %0d, got tdata %h", want,
                              rsp_tdata);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            overlap_q.push_back(boxes_overlap(req_tdata));
         end
         flags_pending = overlap_q.size();
      end
   end

endmodule

// ----- sim/tb.sv -----
// Testbench top of the oriented box overlap test unit: it drives box pairs with
// random gaps and stalls and gives the verdict. Depends on obox_pkg, the unit and
// oriented_box_overlap_test_checker.
`timescale 1ns / 100ps

module tb;
   import obox_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [215:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [7:0]   rsp_tdata;
   int           mismatches;
   int           flags_pending;
   bit           hold_off = 1'b0;

   always #5 clock = ~clock;

   oriented_box_overlap_test_unit dut (.*);

   oriented_box_overlap_test_checker checker_i (.*);

   function automatic logic [104:0] make_box(input logic [23:0] left, input logic [23:0] top,
                                             input logic [21:0] w, input logic [21:0] h,
                                             input logic [12:0] ang);
      return {ang, h, w, top, left};
   endfunction

   function automatic logic [104:0] random_box(input int cx, input int cy);
      logic [23:0] left, top;
      logic [21:0] w, h;
      logic [12:0] ang;
      int mode;
      mode = $urandom_range(0, 9);
      if (mode == 0) begin
         left = 24'($urandom);
         top = 24'($urandom);
         w = 22'($urandom);
         h = 22'($urandom);
      end else begin
         left = 24'(cx + $signed($urandom_range(0, 8192)) - 4096);
         top = 24'(cy + $signed($urandom_range(0, 8192)) - 4096);
         w = (mode == 1) ? 22'($urandom_range(0, 3)) : 22'($urandom_range(0, 6000));
         h = (mode == 2) ? 22'($urandom_range(0, 3)) : 22'($urandom_range(0, 6000));
      end
      ang = ($urandom_range(0, 7) == 0) ? 13'($urandom) : 13'($urandom_range(0, 5759));
      return make_box(left, top, w, h, ang);
   endfunction

   task automatic send_pair(input logic [104:0] a, input logic [104:0] b);
      req_tvalid <= 1'b1;
      req_tdata <= {6'd0, b, a};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic sender_gap();
      int n;
      n = $urandom_range(0, 99);
      if (n < 60) return;
      req_tvalid <= 1'b0;
      req_tdata <= 216'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom});
      repeat ((n < 95) ? $urandom_range(1, 3) : $urandom_range(10, 60)) @(posedge clock);
   endtask

   initial begin
      int mode;
      mode = 0;
      repeat (6) @(posedge clock);
      forever begin
         if (hold_off) begin
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_off = 1'b0;
         end else begin
            if ($urandom_range(0, 49) == 0) mode = $urandom_range(0, 3);
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 3) != 0);
               2: rsp_tready <= ($urandom_range(0, 1) != 0);
               default: rsp_tready <= ($urandom_range(0, 19) == 0);
            endcase
            @(posedge clock);
         end
      end
   end

   initial begin
      #5ms;
      $display("** oriented_box_overlap_test_unit: FAILED **");
      $finish;
   end

   initial begin
      int cx, cy;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Extremes, zero sizes, wrapped angles and touching edges.
      send_pair(make_box(24'h800000, 24'h800000, 22'h3FFFFF, 22'h3FFFFF, 13'd0),
                make_box(24'h7FFFFF, 24'h7FFFFF, 22'h3FFFFF, 22'h3FFFFF, 13'd5759));
      send_pair(make_box(24'h7FFFFF, 24'h800000, 22'h3FFFFF, 22'd0, 13'd8191),
                make_box(24'h800000, 24'h7FFFFF, 22'd0, 22'h3FFFFF, 13'd1440));
      send_pair(make_box(24'd0, 24'd0, 22'd256, 22'd256, 13'd0),
                make_box(24'd256, 24'd0, 22'd256, 22'd256, 13'd0));
      send_pair(make_box(24'd0, 24'd0, 22'd256, 22'd256, 13'd0),
                make_box(24'd257, 24'd0, 22'd256, 22'd256, 13'd0));
      send_pair(make_box(24'd0, 24'd0, 22'd256, 22'd256, 13'd0),
                make_box(24'd0, 24'd256, 22'd256, 22'd256, 13'd5760));
      send_pair(make_box(24'd0, 24'd0, 22'd0, 22'd0, 13'd0),
                make_box(24'd0, 24'd0, 22'd0, 22'd0, 13'd0));
      send_pair(make_box(24'd0, 24'd0, 22'd0, 22'd0, 13'd720),
                make_box(24'd1, 24'd0, 22'd0, 22'd0, 13'd2880));
      send_pair(make_box(24'd0, 24'd0, 22'd1000, 22'd100, 13'd720),
                make_box(24'd600, 24'd600, 22'd100, 22'd1000, 13'd4320));
      send_pair(make_box(24'd0, 24'd0, 22'd512, 22'd512, 13'd720),
                make_box(24'd620, 24'd0, 22'd256, 22'd256, 13'd0));
      send_pair(make_box(24'd0, 24'd0, 22'd512, 22'd512, 13'd2880),
                make_box(24'd0, 24'd620, 22'd256, 22'd256, 13'd7200));
      send_pair(make_box(24'hFFFF00, 24'hFFFF00, 22'd512, 22'd512, 13'd1),
                make_box(24'd0, 24'd0, 22'd512, 22'd512, 13'd5759));
      send_pair(make_box(24'h123456, 24'hEDCBA9, 22'h2AAAAA, 22'h155555, 13'h1555),
                make_box(24'hEDCBA9, 24'h123456, 22'h155555, 22'h2AAAAA, 13'h0AAA));

      for (int i = 0; i < 1540; i++) begin
         if (i == 400) hold_off = 1'b1;
         if (i == 800) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (flags_pending != 0) @(posedge clock);
         end
         cx = $signed($urandom_range(0, 4000)) - 2000;
         cy = $signed($urandom_range(0, 4000)) - 2000;
         send_pair(random_box(cx, cy), random_box(cx, cy));
         if (i < 300 || i >= 600) sender_gap();
      end
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (flags_pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("** oriented_box_overlap_test_unit: PASSED **");
      end else begin
         $display("** oriented_box_overlap_test_unit: FAILED **");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/obox_pkg.sv
rtl/core/obox_sin_rom.sv
rtl/core/obox_box_geom.sv
rtl/core/obox_sat.sv
rtl/core/oriented_box_overlap_test_unit.sv
rtl/core/obox_checker.sv
sim/oriented_box_overlap_test_checker.sv
sim/tb.sv
